FILE: rtl/acrc_pkg.sv
package acrc_pkg;

  // Default fraction width of all ratio and duty values
  localparam int FRAC_BITS_DEF = 20;

  // Item kinds
  localparam logic [1:0] OP_LOCAL  = 2'd0;
  localparam logic [1:0] OP_GLOBAL = 2'd1;
  localparam logic [1:0] OP_STEP   = 2'd2;

  // Register map: index = paddr[4:2]
  localparam int CFG_ADDR_W = 5;
  localparam logic [2:0] REG_LOAD_TARGET    = 3'd0;
  localparam logic [2:0] REG_OFFSET_GAIN    = 3'd1;
  localparam logic [2:0] REG_DECAY_WEIGHT   = 3'd2;
  localparam logic [2:0] REG_OFFSET_CEILING = 3'd3;
  localparam logic [2:0] REG_OFFSET_FLOOR   = 3'd4;
  localparam logic [2:0] REG_DUTY_MAX       = 3'd5;
  localparam logic [2:0] REG_DUTY_MIN       = 3'd6;

  // Reset values are given at 20 fractional bits
  localparam int RESET_FRAC = 20;

  function automatic logic [31:0] scale_fx(input logic [31:0] v, input int f);
    logic [31:0] r;
    if (f >= RESET_FRAC) begin
      r = v << (f - RESET_FRAC);
    end else begin
      r = v >> (RESET_FRAC - f);
    end
    return r;
  endfunction

endpackage

FILE: rtl/adaptive_congestion_rate_control.sv
// Registers: an item passes the input/product register, the seed register
//   and the result register before its result is valid.
// Throughput: one item per cycle while out_ready does not stall the output;
//   the seed division by 100000 is a split reciprocal multiply spread over the first two stages.
// Reset (rst, synchronous): clears histories, smoothed ratio, duty and all
//   valid flags, and loads the default configuration values.
module adaptive_congestion_rate_control #(
  parameter int FRAC_BITS = acrc_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [acrc_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        op,
  input  logic [FRAC_BITS:0]                load_ratio,
  input  logic                              ratio_ok,
  input  logic [15:0]                       on_time_us,
  // output channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [FRAC_BITS:0]                duty,
  output logic [FRAC_BITS:0]                smoothed_load,
  output logic                              did_update,
  output logic                              smoothed_ok
);
  import acrc_pkg::*;

  localparam int FW = FRAC_BITS + 1;
  localparam logic [FW-1:0] ONE_FX = FW'(1) << FRAC_BITS;

  // seed = floor(t * 2^F / 100000) = floor(t * 2^(F-5) / 3125)
  //      = (t * ceil(2^(F+23) / 3125)) >> 28, exact for 16-bit t
  localparam int RW = FRAC_BITS + 12;
  localparam int HW = (RW + 1) / 2;
  localparam int SEED_SHIFT = 28;
  localparam int SW = FRAC_BITS + 28;
  localparam logic [RW-1:0] SEED_RECIP =
    RW'(((64'd1 << (FRAC_BITS + 23)) + 64'd3124) / 64'd3125);
  localparam logic [FW-1:0] SEED_FLOOR =
    FW'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);

  localparam logic [FW-1:0] RST_TARGET  = FW'(scale_fx(32'd713032, FRAC_BITS));
  localparam logic [FW-1:0] RST_GAIN    = FW'(scale_fx(32'd1258, FRAC_BITS));
  localparam logic [FW-1:0] RST_DECAY   = FW'(scale_fx(32'd16777, FRAC_BITS));
  localparam logic [FW-1:0] RST_CEILING = FW'(scale_fx(32'd524, FRAC_BITS));
  localparam logic [FW-1:0] RST_FLOOR   = FW'(32'd0 - scale_fx(32'd262, FRAC_BITS));
  localparam logic [FW-1:0] RST_MAX     = FW'(scale_fx(32'd31457, FRAC_BITS));
  localparam logic [FW-1:0] RST_MIN     = FW'(scale_fx(32'd629, FRAC_BITS));

  function automatic logic [FW-1:0] sat_one(input logic [FW-1:0] v);
    return (v[FW-1] && (|v[FW-2:0])) ? ONE_FX : v;
  endfunction

  // configuration registers
  logic [FW-1:0] load_target, offset_gain, decay_weight, offset_ceiling;
  logic [FW-1:0] offset_floor, duty_max, duty_min;

  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_target    <= RST_TARGET;
      offset_gain    <= RST_GAIN;
      decay_weight   <= RST_DECAY;
      offset_ceiling <= RST_CEILING;
      offset_floor   <= RST_FLOOR;
      duty_max       <= RST_MAX;
      duty_min       <= RST_MIN;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_LOAD_TARGET:    load_target    <= pwdata[FW-1:0];
        REG_OFFSET_GAIN:    offset_gain    <= pwdata[FW-1:0];
        REG_DECAY_WEIGHT:   decay_weight   <= pwdata[FW-1:0];
        REG_OFFSET_CEILING: offset_ceiling <= pwdata[FW-1:0];
        REG_OFFSET_FLOOR:   offset_floor   <= pwdata[FW-1:0];
        REG_DUTY_MAX:       duty_max       <= pwdata[FW-1:0];
        REG_DUTY_MIN:       duty_min       <= pwdata[FW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_LOAD_TARGET:    prdata = 32'(load_target);
      REG_OFFSET_GAIN:    prdata = 32'(offset_gain);
      REG_DECAY_WEIGHT:   prdata = 32'(decay_weight);
      REG_OFFSET_CEILING: prdata = 32'(offset_ceiling);
      REG_OFFSET_FLOOR:   prdata = 32'(offset_floor);
      REG_DUTY_MAX:       prdata = 32'(duty_max);
      REG_DUTY_MIN:       prdata = 32'(duty_min);
      default:            prdata = 32'd0;
    endcase
  end

  // pipeline flow control
  logic s1_valid, s2_valid;
  logic out_load, s2_move, s2_free, s1_move, s1_free;

  assign out_load = !out_valid || out_ready;
  assign s2_move  = s2_valid && out_load;
  assign s2_free  = !s2_valid || out_load;
  assign s1_move  = s1_valid && s2_free;
  assign s1_free  = !s1_valid || s2_free;
  assign in_ready = s1_free;

  // stage 1: item fields and seed partial products
  logic [1:0]           s1_op;
  logic [FW-1:0]        s1_ratio;
  logic                 s1_ok;
  logic [16+HW-1:0]     s1_pl;
  logic [16+RW-HW-1:0]  s1_ph;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_free) begin
      s1_op    <= op;
      s1_ratio <= sat_one(load_ratio);
      s1_ok    <= ratio_ok;
      s1_pl    <= (16+HW)'(on_time_us) * (16+HW)'(SEED_RECIP[HW-1:0]);
      s1_ph    <= (16+RW-HW)'(on_time_us) * (16+RW-HW)'(SEED_RECIP[RW-1:HW]);
    end
  end

  // stage 2: seed with its floor
  logic [SW-1:0]  seed_sum;
  logic [FW-1:0]  seed_q;
  logic [1:0]     s2_op;
  logic [FW-1:0]  s2_ratio;
  logic           s2_ok;
  logic [FW-1:0]  s2_seed;

  assign seed_sum = {s1_ph, {HW{1'b0}}} + SW'(s1_pl);
  assign seed_q   = FW'(seed_sum[SW-1:SEED_SHIFT]);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_op    <= s1_op;
      s2_ratio <= s1_ratio;
      s2_ok    <= s1_ok;
      s2_seed  <= (seed_q < SEED_FLOOR) ? SEED_FLOOR : seed_q;
    end
  end

  // state; the older local entry is not kept, since a step averages the
  // incoming sample with the newest stored one
  logic [FW-1:0] local_hist0, global_hist0, global_hist1;
  logic          global_seen, smoothed_set;
  logic [FW-1:0] smoothed_ratio, duty_fraction;

  // control update, evaluated on the item in stage 2
  logic [FW-1:0]        avg, s_new;
  logic signed [FW:0]   diff, offset;
  logic [FW-1:0]        mag, offm, old_duty, keep, kp;
  logic [2*FW-1:0]      gprod, kprod;
  logic signed [FW:0]   offn, flr;
  logic signed [FW+1:0] nd, hi, lo;
  logic [FW-1:0]        duty_upd;
  logic                 run_step;

  assign run_step = (s2_op == OP_STEP) && s2_ok;

  always_comb begin
    if (global_seen) begin
      avg = FW'(({1'b0, global_hist0} + {1'b0, global_hist1}) >> 1);
    end else begin
      // the new sample is already the newest local entry
      avg = FW'(({1'b0, s2_ratio} + {1'b0, local_hist0}) >> 1);
    end
    if (smoothed_set) begin
      s_new = FW'(({1'b0, smoothed_ratio} + {1'b0, avg}) >> 1);
    end else begin
      s_new = avg;
    end

    diff  = $signed({1'b0, sat_one(load_target)}) - $signed({1'b0, s_new});
    mag   = diff[FW] ? FW'(-diff) : diff[FW-1:0];
    gprod = (2*FW)'(sat_one(offset_gain)) * (2*FW)'(mag);
    offm  = gprod[FRAC_BITS +: FW];
    offn  = -$signed({1'b0, offm});
    flr   = $signed({offset_floor[FW-1], offset_floor});
    // zero difference goes the negative way
    if (!diff[FW] && (|diff)) begin
      offset = (offm > sat_one(offset_ceiling)) ? $signed({1'b0, sat_one(offset_ceiling)})
                                                : $signed({1'b0, offm});
    end else begin
      offset = (offn < flr) ? flr : offn;
    end

    old_duty = (duty_fraction == '0) ? s2_seed : duty_fraction;
    keep     = ONE_FX - sat_one(decay_weight);
    kprod    = (2*FW)'(keep) * (2*FW)'(old_duty);
    kp       = kprod[FRAC_BITS +: FW];

    nd = $signed({2'b00, kp}) + $signed({offset[FW], offset});
    hi = $signed({2'b00, sat_one(duty_max)});
    lo = $signed({2'b00, sat_one(duty_min)});
    if (nd > hi) begin
      nd = hi;
    end
    // minimum wins over maximum
    if (nd < lo) begin
      nd = lo;
    end
    duty_upd = nd[FW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      local_hist0    <= '0;
      global_hist0   <= '0;
      global_hist1   <= '0;
      global_seen    <= 1'b0;
      smoothed_ratio <= '0;
      smoothed_set   <= 1'b0;
      duty_fraction  <= '0;
    end else if (s2_move) begin
      case (s2_op)
        OP_LOCAL, OP_STEP: begin
          local_hist0 <= s2_ok ? s2_ratio : '0;
          if (run_step) begin
            smoothed_ratio <= s_new;
            smoothed_set   <= 1'b1;
            duty_fraction  <= duty_upd;
          end
        end
        OP_GLOBAL: begin
          global_hist1 <= global_hist0;
          global_hist0 <= s2_ratio;
          global_seen  <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      duty          <= run_step ? duty_upd : duty_fraction;
      smoothed_load <= run_step ? s_new : smoothed_ratio;
      did_update    <= run_step;
      smoothed_ok   <= run_step || smoothed_set;
    end
  end

endmodule

FILE: rtl/acrc_checker.sv
module acrc_checker #(
  parameter int FRAC_BITS = acrc_pkg::FRAC_BITS_DEF
) (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [FRAC_BITS:0] duty,
  input logic [FRAC_BITS:0] smoothed_load,
  input logic               did_update,
  input logic               smoothed_ok
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(duty) && $stable(smoothed_load)
      && $stable(did_update) && $stable(smoothed_ok))
    else $error("result changed while stalled");

  a_update_sets: assert property (@(posedge clk) disable iff (rst)
    out_valid && did_update |-> smoothed_ok)
    else $error("update without smoothed ratio set");

  a_unset_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !smoothed_ok |-> smoothed_load == '0 && !did_update)
    else $error("smoothed ratio nonzero before first update");

  // once set, the smoothed ratio stays set until reset
  a_ok_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && smoothed_ok |=> !out_valid || smoothed_ok)
    else $error("smoothed_ok dropped");

endmodule

bind adaptive_congestion_rate_control acrc_checker #(.FRAC_BITS(FRAC_BITS)) u_acrc_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .duty          (duty),
  .smoothed_load (smoothed_load),
  .did_update    (did_update),
  .smoothed_ok   (smoothed_ok)
);
